// ----- design/i4l2_pkg.sv -----
// Shared types, constants and helpers of the int4 dequantize L2 distance block.
package i4l2_pkg;

   localparam int DIMS         = 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam int Div          = 15;
   localparam int RoundBias    = 7;
   localparam int Recip15      = 137;
   localparam int Recip15Shift = 11;
   localparam int QUO_W        = 28;
   localparam int REM_W        = 4;

   // floor(n / 15) = (n * Recip15Wide) >> Recip15WideShift for any 32-bit n
   localparam logic [31:0] Recip15Wide      = 32'h8888_8889;
   localparam int          Recip15WideShift = 35;

   localparam logic [63:0] SAT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [DIMS-1:0][3:0]       nib;
      logic [DIMS-1:0][31:0]      query;
      logic [DIMS-1:0][31:0]      min_val;
      logic [DIMS-1:0][QUO_W-1:0] quo;
      logic [DIMS-1:0][REM_W-1:0] rem;
      logic                       second_valid;
      logic                       last_pair;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // floor(t / 15) for t below 240
   function automatic logic [4:0] div15_narrow(input logic [7:0] t);
      logic [15:0] p;
      p = 16'(t) * 16'(Recip15);
      return p[Recip15Shift +: 5];
   endfunction

endpackage

// ----- design/i4l2_front.sv -----
// Front end: accepts items, unpacks codes and splits each span into span/15 and span%15.
module i4l2_front (
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [7:0]                  req_code_byte,
   input  logic signed [31:0]          req_query_first,
   input  logic signed [31:0]          req_query_second,
   input  logic signed [31:0]          req_min_first,
   input  logic signed [31:0]          req_min_second,
   input  logic [30:0]                 req_span_first,
   input  logic [30:0]                 req_span_second,
   input  logic                        req_second_valid,
   input  logic                        req_last_pair,
   input  i4l2_pkg::queue_status_type  q_status,
   output logic                        q_wr,
   output i4l2_pkg::entry_type         q_entry
);

   typedef struct packed {
      logic [i4l2_pkg::QUO_W-1:0] quo;
      logic [i4l2_pkg::REM_W-1:0] rem;
   } div_type;

   // quotient by reciprocal multiplication, remainder by multiply-back
   function automatic div_type span_div15(input logic [30:0] span);
      logic [63:0] p;
      logic [31:0] back_mul;
      div_type     res;
      p = 64'(span) * 64'(i4l2_pkg::Recip15Wide);
      res.quo = p[i4l2_pkg::Recip15WideShift +: i4l2_pkg::QUO_W];
      back_mul = 32'(res.quo) * 32'(i4l2_pkg::Div);
      res.rem = 4'(32'(span) - back_mul);
      return res;
   endfunction

   div_type div_first;
   div_type div_second;

   assign div_first  = span_div15(req_span_first);
   assign div_second = span_div15(req_span_second);

   assign req_full = q_status.full;
   assign q_wr     = req_push && !q_status.full;

   always_comb begin
      q_entry.nib[0]       = req_code_byte[7:4];
      q_entry.nib[1]       = req_code_byte[3:0];
      q_entry.query[0]     = req_query_first;
      q_entry.query[1]     = req_query_second;
      q_entry.min_val[0]   = req_min_first;
      q_entry.min_val[1]   = req_min_second;
      q_entry.quo[0]       = div_first.quo;
      q_entry.quo[1]       = div_second.quo;
      q_entry.rem[0]       = div_first.rem;
      q_entry.rem[1]       = div_second.rem;
      q_entry.second_valid = req_second_valid;
      q_entry.last_pair    = req_last_pair;
   end

endmodule

// ----- design/i4l2_queue.sv -----
// Short item queue between front end and back end.
module i4l2_queue #(
   parameter int DEPTH = i4l2_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  i4l2_pkg::entry_type         wr_entry,
   input  logic                        rd_en,
   output i4l2_pkg::entry_type         rd_entry,
   output i4l2_pkg::queue_status_type  status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   i4l2_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign rd_entry     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// ----- design/i4l2_back.sv -----
// Back end: dequantize, difference, square and saturating accumulation pipeline.
module i4l2_back (
   input  logic                        clock,
   input  logic                        reset,
   input  i4l2_pkg::queue_status_type  q_status,
   input  i4l2_pkg::entry_type         q_entry,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [63:0]                 rsp_distance_sq
);

   localparam int D = i4l2_pkg::DIMS;

   logic adv;

   logic                       v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                       sv1_ff, sv2_ff, sv3_ff, sv4_ff;
   logic                       last1_ff, last2_ff, last3_ff, last4_ff, last5_ff;
   logic [D-1:0][31:0]         scaled1_ff, scaled1_in;
   logic [D-1:0][31:0]         query1_ff, min1_ff;
   logic [D-1:0][33:0]         diff2_ff, diff2_in;
   logic [D-1:0][31:0]         mag3_ff, mag3_in;
   logic [D-1:0]               big3_ff, big3_in;
   logic [D-1:0][63:0]         sq4_ff, sq4_in;
   logic [63:0]                pair5_ff, pair5_in;
   logic [63:0]                acc_ff, acc_in;
   logic [63:0]                out_ff;
   logic                       out_valid_ff, out_valid_in;
   logic [63:0]                sum;

   assign adv       = !out_valid_ff || rsp_pop;
   assign q_pop     = adv && !q_status.empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_distance_sq = out_ff;

   always_comb begin
      logic [31:0] prod;
      logic [7:0]  small_in;
      logic [4:0]  small_q;
      logic [33:0] neg;
      logic [64:0] pair_w;
      logic [64:0] sum_w;
      for (int d = 0; d < D; d++) begin
         prod = 32'(q_entry.nib[d]) * 32'(q_entry.quo[d]);
         small_in = 8'(q_entry.nib[d]) * 8'(q_entry.rem[d]) + 8'(i4l2_pkg::RoundBias);
         small_q = i4l2_pkg::div15_narrow(small_in);
         scaled1_in[d] = prod + 32'(small_q);

         diff2_in[d] = {{2{query1_ff[d][31]}}, query1_ff[d]}
                     - {{2{min1_ff[d][31]}}, min1_ff[d]}
                     - {2'b00, scaled1_ff[d]};

         neg = -diff2_ff[d];
         mag3_in[d] = diff2_ff[d][33] ? neg[31:0] : diff2_ff[d][31:0];
         big3_in[d] = diff2_ff[d][33] ? (neg[33:32] != 2'b00) : (diff2_ff[d][33:32] != 2'b00);

         sq4_in[d] = big3_ff[d] ? i4l2_pkg::SAT_MAX : 64'(mag3_ff[d]) * 64'(mag3_ff[d]);
      end

      pair_w = {1'b0, sq4_ff[0]} + {1'b0, (sv4_ff ? sq4_ff[1] : 64'd0)};
      pair5_in = pair_w[64] ? i4l2_pkg::SAT_MAX : pair_w[63:0];

      sum_w = {1'b0, acc_ff} + {1'b0, pair5_ff};
      sum = sum_w[64] ? i4l2_pkg::SAT_MAX : sum_w[63:0];

      acc_in = acc_ff;
      if (adv && v5_ff) begin
         acc_in = last5_ff ? 64'd0 : sum;
      end
      out_valid_in = (out_valid_ff && !rsp_pop) || (adv && v5_ff && last5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            v1_ff <= q_pop;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
            v5_ff <= v4_ff;
         end
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         scaled1_ff <= scaled1_in;
         query1_ff  <= q_entry.query;
         min1_ff    <= q_entry.min_val;
         sv1_ff     <= q_entry.second_valid;
         last1_ff   <= q_entry.last_pair;
         diff2_ff   <= diff2_in;
         sv2_ff     <= sv1_ff;
         last2_ff   <= last1_ff;
         mag3_ff    <= mag3_in;
         big3_ff    <= big3_in;
         sv3_ff     <= sv2_ff;
         last3_ff   <= last2_ff;
         sq4_ff     <= sq4_in;
         sv4_ff     <= sv3_ff;
         last4_ff   <= last3_ff;
         pair5_ff   <= pair5_in;
         last5_ff   <= last4_ff;
      end
      if (adv && v5_ff && last5_ff) begin
         out_ff <= sum;
      end
   end

endmodule

// ----- design/int4_dequant_l2_distance.sv -----
// Top level: int4 dequantize squared L2 distance.
// Throughput: one item per cycle through the back-end pipeline, stalled while a result waits for rsp_pop.
// A last-pair item's result shows once it has passed the queue, the back-end stages and the output register.
// Input queue of QUEUE_DEPTH items decouples the front end from the back end.
// Synchronous active-high reset empties the queue and output and clears the sum.
module int4_dequant_l2_distance #(
   parameter int QUEUE_DEPTH = i4l2_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_code_byte,
   input  logic signed [31:0] req_query_first,
   input  logic signed [31:0] req_query_second,
   input  logic signed [31:0] req_min_first,
   input  logic signed [31:0] req_min_second,
   input  logic [30:0]        req_span_first,
   input  logic [30:0]        req_span_second,
   input  logic               req_second_valid,
   input  logic               req_last_pair,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [63:0]        rsp_distance_sq
);

   i4l2_pkg::queue_status_type q_status;
   i4l2_pkg::entry_type        wr_entry;
   i4l2_pkg::entry_type        rd_entry;
   logic                       q_wr;
   logic                       q_pop;

   i4l2_front u_front (
      .req_push         (req_push),
      .req_full         (req_full),
      .req_code_byte    (req_code_byte),
      .req_query_first  (req_query_first),
      .req_query_second (req_query_second),
      .req_min_first    (req_min_first),
      .req_min_second   (req_min_second),
      .req_span_first   (req_span_first),
      .req_span_second  (req_span_second),
      .req_second_valid (req_second_valid),
      .req_last_pair    (req_last_pair),
      .q_status         (q_status),
      .q_wr             (q_wr),
      .q_entry          (wr_entry)
   );

   i4l2_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr),
      .wr_entry (wr_entry),
      .rd_en    (q_pop),
      .rd_entry (rd_entry),
      .status   (q_status)
   );

   i4l2_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_entry         (rd_entry),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_distance_sq (rsp_distance_sq)
   );

`ifndef SYNTH
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue popped while empty");

   a_hold_blocks_pop: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |-> !q_pop)
      else $error("back end advanced while result held");

   a_reset_clean: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("not empty after reset");
`endif

endmodule

// ----- test/int4_dequant_l2_distance_tb.sv -----
// Testbench for int4_dequant_l2_distance: random and directed pairs checked against a predictor.
module int4_dequant_l2_distance_tb;

   typedef struct {
      logic [7:0]         code;
      logic signed [31:0] query_a;
      logic signed [31:0] query_b;
      logic signed [31:0] floor_a;
      logic signed [31:0] floor_b;
      logic [30:0]        span_a;
      logic [30:0]        span_b;
      logic               second_valid;
      logic               last_pair;
      bit                 drain;
   } pair_item_type;

   typedef enum int {RANGE_TIGHT, RANGE_WIDE, RANGE_EDGE} value_range_type;
   typedef enum int {POP_ALWAYS, POP_COIN, POP_BURSTY, POP_PATTERN} pop_mode_type;

   localparam int RANDOM_PAIRS = 1250;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [7:0]         req_code_byte = '0;
   logic signed [31:0] req_query_first = '0;
   logic signed [31:0] req_query_second = '0;
   logic signed [31:0] req_min_first = '0;
   logic signed [31:0] req_min_second = '0;
   logic [30:0]        req_span_first = '0;
   logic [30:0]        req_span_second = '0;
   logic               req_second_valid = 1'b0;
   logic               req_last_pair = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [63:0]        rsp_distance_sq;

   pair_item_type pairs_pending[$];
   logic [63:0]   distances_due[$];
   logic [63:0]   running_dist = '0;
   int            pairs_made = 0;
   int            pairs_taken = 0;
   int            odd_tails = 0;
   int            distances_seen = 0;
   int            saturated_seen = 0;
   int            error_count = 0;
   int            burst_left = 0;
   int            gap_left = 0;
   int            stall_left = 0;
   int            pop_cycles = 0;
   pop_mode_type  pop_mode = POP_ALWAYS;

   int4_dequant_l2_distance uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_code_byte    (req_code_byte),
      .req_query_first  (req_query_first),
      .req_query_second (req_query_second),
      .req_min_first    (req_min_first),
      .req_min_second   (req_min_second),
      .req_span_first   (req_span_first),
      .req_span_second  (req_span_second),
      .req_second_valid (req_second_valid),
      .req_last_pair    (req_last_pair),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_distance_sq  (rsp_distance_sq)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [63:0] dim_square(input logic [3:0] nib,
                                              input logic signed [31:0] query,
                                              input logic signed [31:0] floor_val,
                                              input logic [30:0] span);
      logic [63:0] scaled;
      longint      deq;
      longint      diff;
      logic [63:0] mag;
      scaled = (64'(nib) * 64'(span) + 64'd7) / 64'd15;
      deq = longint'(floor_val) + longint'(scaled);
      diff = longint'(query) - deq;
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      if (mag >= 64'h1_0000_0000) return i4l2_pkg::SAT_MAX;
      return mag * mag;
   endfunction

   function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? i4l2_pkg::SAT_MAX : s[63:0];
   endfunction

   // fold the item now on the ports into the running distance
   task automatic accumulate_pair();
      logic [63:0] acc;
      acc = sat_sum(running_dist, dim_square(req_code_byte[7:4], req_query_first,
                                             req_min_first, req_span_first));
      if (req_second_valid)
         acc = sat_sum(acc, dim_square(req_code_byte[3:0], req_query_second,
                                       req_min_second, req_span_second));
      else
         odd_tails++;
      if (req_last_pair) begin
         distances_due.push_back(acc);
         running_dist = '0;
      end else begin
         running_dist = acc;
      end
   endtask

   function automatic pair_item_type make_pair(input logic [7:0] code,
                                               input logic [31:0] qa, input logic [31:0] qb,
                                               input logic [31:0] fa, input logic [31:0] fb,
                                               input logic [30:0] sa, input logic [30:0] sb,
                                               input logic sv, input logic lp);
      pair_item_type p;
      p.code = code;
      p.query_a = qa;
      p.query_b = qb;
      p.floor_a = fa;
      p.floor_b = fb;
      p.span_a = sa;
      p.span_b = sb;
      p.second_valid = sv;
      p.last_pair = lp;
      p.drain = 1'b0;
      return p;
   endfunction

   function automatic logic [31:0] edge_word();
      case ($urandom_range(0, 6))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3: return 32'h7FFF_FFFF;
         4: return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [30:0] edge_span();
      case ($urandom_range(0, 4))
         0: return 31'h0;
         1: return 31'h1;
         2: return 31'h7FFF_FFFF;
         3: return 31'h4000_0000;
         default: return 31'($urandom());
      endcase
   endfunction

   function automatic void random_dim(input value_range_type rng, output logic [31:0] query,
                                      output logic [31:0] floor_val,
                                      output logic [30:0] span);
      case (rng)
         RANGE_TIGHT: begin
            floor_val = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            span = 31'($urandom_range(0, 32'h0010_0000));
            query = floor_val + $urandom_range(0, 32'(span)) + $urandom_range(0, 8192) - 4096;
         end
         RANGE_WIDE: begin
            floor_val = $urandom();
            span = 31'($urandom());
            query = $urandom();
         end
         default: begin
            floor_val = edge_word();
            span = edge_span();
            query = edge_word();
         end
      endcase
   endfunction

   function automatic pair_item_type random_pair(input value_range_type rng, input logic sv,
                                                 input logic lp);
      pair_item_type p;
      p.code = 8'($urandom());
      random_dim(rng, p.query_a, p.floor_a, p.span_a);
      random_dim(rng, p.query_b, p.floor_b, p.span_b);
      p.second_valid = sv;
      p.last_pair = lp;
      p.drain = 1'b0;
      return p;
   endfunction

   task automatic drive_pair(input pair_item_type p, input logic push);
      req_push <= push;
      req_code_byte <= p.code;
      req_query_first <= p.query_a;
      req_query_second <= p.query_b;
      req_min_first <= p.floor_a;
      req_min_second <= p.floor_b;
      req_span_first <= p.span_a;
      req_span_second <= p.span_b;
      req_second_valid <= p.second_valid;
      req_last_pair <= p.last_pair;
   endtask

   // sender: bursts and gaps, holding a drain-marked item until all distances are back
   always @(posedge clock) begin
      bit present;
      present = 1'b0;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            accumulate_pair();
            void'(pairs_pending.pop_front());
            pairs_taken++;
         end
         if (pairs_pending.size() == 0 ||
             (pairs_pending[0].drain && distances_due.size() != 0)) begin
            present = 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
         end else begin
            present = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                       : $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (present)
            drive_pair(pairs_pending[0], 1'b1);
         else
            drive_pair(random_pair(RANGE_WIDE, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))), 1'b0);
      end
   end

   // receiver: check each popped distance, stalling as set by a pop mode that changes at random
   always @(posedge clock) begin
      logic [63:0] want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (distances_due.size() == 0) begin
               $error("distance_sq: no item expected, actual %h", rsp_distance_sq);
               error_count++;
            end else begin
               want = distances_due.pop_front();
               distances_seen++;
               if (want == i4l2_pkg::SAT_MAX) saturated_seen++;
               if (rsp_distance_sq !== want) begin
                  $error("distance_sq mismatch: expected %h, actual %h", want, rsp_distance_sq);
                  error_count++;
               end
            end
         end
         pop_cycles++;
         if (pop_cycles % 300 == 0) pop_mode = pop_mode_type'($urandom_range(0, 3));
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_mode)
               POP_ALWAYS: rsp_pop <= 1'b1;
               POP_COIN: rsp_pop <= 1'($urandom_range(0, 1));
               POP_BURSTY: begin
                  rsp_pop <= 1'b1;
                  if ($urandom_range(0, 40) == 0) stall_left = $urandom_range(5, 30);
               end
               default: rsp_pop <= (pop_cycles % 7) > 2;
            endcase
         end
      end
   end

   initial begin
      pair_item_type   p;
      value_range_type rng;
      int              len;
      bit              hold_next;
      // directed: zeros, full spans, square and sum saturation, odd tails, rounding
      pairs_pending.push_back(make_pair(8'h00, 0, 0, 0, 0, 31'h0, 31'h0, 1'b1, 1'b1));
      pairs_pending.push_back(make_pair(8'hFF, 0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                        1'b1, 1'b1));
      pairs_pending.push_back(make_pair(8'hF0, 32'h8000_0000, $urandom(), 32'h7FFF_FFFF,
                                        $urandom(), 31'h7FFF_FFFF, 31'($urandom()),
                                        1'b0, 1'b1));
      pairs_pending.push_back(make_pair(8'h00, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h8000_0000, 31'h0, 31'h0, 1'b1, 1'b0));
      pairs_pending.push_back(make_pair(8'h00, 0, 0, 0, 0, 31'h0, 31'h0, 1'b1, 1'b0));
      pairs_pending.push_back(make_pair(8'h11, 32'h0001_0000, 32'hFFFF_0000, 0, 0,
                                        31'h1, 31'h1, 1'b1, 1'b1));
      pairs_pending.push_back(make_pair(8'hFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 31'h0, 31'h0, 1'b1, 1'b1));
      pairs_pending.push_back(make_pair(8'h3C, 32'h0002_8000, 32'hFFFE_0000, 32'hFFFF_0000,
                                        32'h0001_0000, 31'h0005_0000, 31'h0003_0000,
                                        1'b1, 1'b0));
      pairs_pending.push_back(make_pair(8'hA5, 32'h0001_0000, 32'h7FFF_FFFF, 0,
                                        32'h8000_0000, 31'h000F_0000, 31'h7FFF_FFFF,
                                        1'b0, 1'b0));
      pairs_pending.push_back(make_pair(8'h5A, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0,
                                        31'h2, 31'h2, 1'b1, 1'b1));
      pairs_pending.push_back(make_pair(8'h78, 0, 0, 0, 0, 31'h1, 31'h1, 1'b1, 1'b1));
      pairs_pending.push_back(make_pair(8'h84, 0, 0, 0, 0, 31'h2, 31'h2, 1'b1, 1'b1));
      pairs_pending.push_back(make_pair(8'h0F, 32'h0000_1234, 32'h7FFF_FFFF, 32'h0000_1000,
                                        32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                        1'b0, 1'b1));
      pairs_pending.push_back(make_pair(8'hF7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                        32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                        1'b1, 1'b1));
      pairs_made = pairs_pending.size();
      hold_next = 1'b1;
      while (pairs_made < pairs_pending.size() + RANDOM_PAIRS && pairs_made < 1400) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: rng = RANGE_TIGHT;
            12, 13, 14, 15, 16: rng = RANGE_WIDE;
            default: rng = RANGE_EDGE;
         endcase
         len = ($urandom_range(0, 24) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            p = random_pair(rng, $urandom_range(0, 9) != 0, i == len - 1);
            if (i == 0 && hold_next) p.drain = 1'b1;
            pairs_pending.push_back(p);
            pairs_made++;
         end
         hold_next = $urandom_range(0, 99) == 0;
         if (pairs_made >= 14 + RANDOM_PAIRS) break;
      end
      while (pairs_taken < pairs_made) @(posedge clock);
      while (distances_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d pairs (%0d odd tails) and %0d distances, %0d saturated",
               pairs_taken, odd_tails, distances_seen, saturated_seen);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
